FILE: design/page_frame_bitmap_allocator_macros.svh
// Assertion macros used by the page frame bitmap allocator top level.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PFBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PFBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pfba_pkg.sv
// Package of the page frame bitmap allocator: sizes, codes and item types.
`timescale 1ns / 1ps
package pfba_pkg;

  localparam int NUM_FRAMES    = 4096;
  localparam int MAP_WORD_BITS = 32;   // power of two
  localparam int MAP_WORDS     = NUM_FRAMES / MAP_WORD_BITS;
  localparam int ADDR_W        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W         = $clog2(MAP_WORD_BITS);
  localparam int FRAME_W       = 12;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [BIT_W-1:0]         bidx_t;
  typedef logic [MAP_WORD_BITS-1:0] word_t;
  typedef logic [FRAME_W-1:0]       frame_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FREED     = 2'd1,
    ST_UNCHANGED = 2'd2,
    ST_NO_FRAME  = 2'd3
  } status_e;

  typedef struct packed {
    op_e    opcode;
    frame_t current_frame;
    logic   kernel_page;
    logic   writable;
  } req_t;

  typedef struct packed {
    status_e status;
    frame_t  frame_out;
    logic    present_bit;
    logic    rw_bit;
    logic    user_bit;
  } rsp_t;

  // Write-back notice from the sequencer to the summary.
  typedef struct packed {
    logic  we;
    addr_t addr;
    logic  full;
  } upd_t;

endpackage

FILE: design/pfba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module pfba_ram #(
  parameter int Depth = 128,
  parameter int Width = 32,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: design/pfba_summary.sv
// Per-word written and full flags, and the lowest not-full word search.
`timescale 1ns / 1ps
module pfba_summary (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pfba_pkg::upd_t  upd_i,
  input  pfba_pkg::addr_t rd_addr_i,
  output logic          rd_valid_o,
  output pfba_pkg::addr_t free_idx_o,
  output logic          any_free_o
);
  import pfba_pkg::*;

  logic [MAP_WORDS-1:0] valid_q;
  logic [MAP_WORDS-1:0] full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      full_q  <= '0;
    end else if (upd_i.we) begin
      valid_q[upd_i.addr] <= 1'b1;
      full_q[upd_i.addr]  <= upd_i.full;
    end
  end

  // A word never written reads as all free.
  assign rd_valid_o = valid_q[rd_addr_i];

  // Priority encoder: lowest word that still has a free frame.
  always_comb begin
    free_idx_o = '0;
    for (int i = MAP_WORDS - 1; i >= 0; i--) begin
      if (!full_q[i]) begin
        free_idx_o = addr_t'(i);
      end
    end
  end

  assign any_free_o = ~&full_q;

endmodule

FILE: design/page_frame_bitmap_allocator.sv
// Top level of the page frame bitmap allocator: request sequencer and map RAM.
`timescale 1ns / 1ps
//
//  Channel   Ports                     Handshake
//  --------  ------------------------  ---------------------------------------
//  request   req_i (pfba_pkg::req_t)   taken at a rising edge with start && !busy
//  result    rsp_o (pfba_pkg::rsp_t)   valid for one cycle while done_o is high
//
//  An item that needs no map access (entry already mapped on alloc, unmapped
//  entry on free, no free frame, free beyond the map) has its result show in the
//  cycle after it is taken, and busy stays low.
//  An item that touches the map has the map RAM read issued at the accept edge,
//  then the modify and write-back edge; busy is high in between.
//  Reset clears all written flags at once, so no clearing pass is needed.
//  The receiver cannot stall; every result is shown exactly once.
//
`include "page_frame_bitmap_allocator_macros.svh"
module page_frame_bitmap_allocator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  pfba_pkg::req_t req_i,
  output logic           done_o,
  output pfba_pkg::rsp_t rsp_o
);
  import pfba_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_MOD
  } state_e;

  state_e state_q, state_d;

  // Request fields held across the read cycle.
  op_e   op_q,   op_d;
  addr_t addr_q, addr_d;
  bidx_t bit_q,  bit_d;
  logic  kern_q, kern_d;
  logic  wr_q,   wr_d;
  logic  vld_q,  vld_d;

  logic done_q, done_d;
  rsp_t rsp_q,  rsp_d;

  // Summary and RAM hookup.
  upd_t  upd;
  addr_t rd_addr;
  logic  rd_valid;
  addr_t free_idx;
  logic  any_free;
  word_t ram_rdata;
  logic  ram_re;

  // Decode of the incoming request.
  logic   accept;
  logic   cur_zero;
  frame_t cur_word;
  logic   in_map;
  logic   need_mem;

  // Modify stage.
  word_t word;
  word_t new_word;
  word_t bit_mask;
  bidx_t fbit;
  logic [ADDR_W+BIT_W-1:0] frame_full;

  assign accept   = start && (state_q == S_IDLE);
  assign cur_zero = (req_i.current_frame == '0);
  assign cur_word = req_i.current_frame >> BIT_W;
  assign in_map   = (32'(cur_word) < 32'(MAP_WORDS));

  always_comb begin
    if (req_i.opcode == OP_ALLOC) begin
      need_mem = cur_zero && any_free;
      rd_addr  = free_idx;
    end else begin
      need_mem = !cur_zero && in_map;
      rd_addr  = addr_t'(cur_word);
    end
  end

  assign ram_re = accept && need_mem;

  // Treat an unwritten word as all free.
  assign word = vld_q ? ram_rdata : '0;

  // Lowest clear bit of the word being allocated from.
  always_comb begin
    fbit = '0;
    for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
      if (!word[b]) begin
        fbit = bidx_t'(b);
      end
    end
  end

  always_comb begin
    bit_mask = '0;
    if (op_q == OP_ALLOC) begin
      bit_mask[fbit]  = 1'b1;
      new_word = word | bit_mask;
    end else begin
      bit_mask[bit_q] = 1'b1;
      new_word = word & ~bit_mask;
    end
  end

  assign frame_full = {addr_q, fbit};

  assign upd.we   = (state_q == S_MOD);
  assign upd.addr = addr_q;
  assign upd.full = &new_word;

  // Next-state and result logic.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    addr_d  = addr_q;
    bit_d   = bit_q;
    kern_d  = kern_q;
    wr_d    = wr_q;
    vld_d   = vld_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = req_i.opcode;
          addr_d = rd_addr;
          bit_d  = req_i.current_frame[BIT_W-1:0];
          kern_d = req_i.kernel_page;
          wr_d   = req_i.writable;
          vld_d  = rd_valid;
          if (need_mem) begin
            state_d = S_MOD;
          end else begin
            // Answer at once: nothing in the map changes.
            done_d            = 1'b1;
            rsp_d.present_bit = 1'b0;
            rsp_d.rw_bit      = 1'b0;
            rsp_d.user_bit    = 1'b0;
            rsp_d.frame_out   = '0;
            if (req_i.opcode == OP_ALLOC) begin
              if (!cur_zero) begin
                rsp_d.status    = ST_UNCHANGED;
                rsp_d.frame_out = req_i.current_frame;
              end else begin
                rsp_d.status = ST_NO_FRAME;
              end
            end else if (cur_zero) begin
              rsp_d.status = ST_UNCHANGED;
            end else begin
              rsp_d.status = ST_FREED;
            end
          end
        end
      end
      S_MOD: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        if (op_q == OP_ALLOC) begin
          rsp_d.status      = ST_ALLOCATED;
          rsp_d.frame_out   = frame_t'(frame_full);
          rsp_d.present_bit = 1'b1;
          rsp_d.rw_bit      = wr_q;
          rsp_d.user_bit    = !kern_q;
        end else begin
          rsp_d.status      = ST_FREED;
          rsp_d.frame_out   = '0;
          rsp_d.present_bit = 1'b0;
          rsp_d.rw_bit      = 1'b0;
          rsp_d.user_bit    = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      rsp_q   <= '0;
      op_q    <= OP_ALLOC;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      rsp_q   <= rsp_d;
      op_q    <= op_d;
      vld_q   <= vld_d;
    end
  end

  // Payload holds need no reset.
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    bit_q  <= bit_d;
    kern_q <= kern_d;
    wr_q   <= wr_d;
  end

  pfba_summary u_summary (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (upd),
    .rd_addr_i  (rd_addr),
    .rd_valid_o (rd_valid),
    .free_idx_o (free_idx),
    .any_free_o (any_free)
  );

  pfba_ram #(
    .Depth (MAP_WORDS),
    .Width (MAP_WORD_BITS),
    .AddrW (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (upd.we),
    .waddr_i (addr_q),
    .wdata_i (new_word),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `PFBA_ASSERT_NEXT(a_mod_one_cycle, busy, !busy, "modify stage lasted more than one cycle")
  `PFBA_ASSERT_NEXT(a_mod_done, busy, done_o, "map access ended without a result")
  `PFBA_ASSERT_NEXT(a_direct_done, accept && !need_mem, done_o && !busy,
                    "request without map access gave no result")
  `PFBA_ASSERT_NOW(a_alloc_present, done_o && (rsp_o.status == ST_ALLOCATED),
                   rsp_o.present_bit, "allocated frame without present bit")

endmodule

FILE: sim/testbench.sv
// Self-checking testbench of the page frame bitmap allocator.
`timescale 1ns / 1ps

// Keeps its own copy of the used-frame map. It predicts each item's result and
// checks the results against those predictions in order.
class frame_map_scoreboard;
  pfba_pkg::word_t used_words [pfba_pkg::MAP_WORDS];
  pfba_pkg::rsp_t  pending_results [$];
  int unsigned     mismatches;
  int unsigned     status_count [4];

  function new();
    foreach (used_words[w]) used_words[w] = '0;
    foreach (status_count[s]) status_count[s] = 0;
    mismatches = 0;
  endfunction

  // Work out the item's result, apply it to the map, queue it.
  function pfba_pkg::rsp_t book_request(pfba_pkg::req_t r);
    pfba_pkg::rsp_t rsp;
    bit             found;
    int             w;
    int             b;
    rsp        = '0;
    rsp.status = pfba_pkg::ST_UNCHANGED;
    if (r.opcode == pfba_pkg::OP_ALLOC) begin
      if (r.current_frame != '0) begin
        rsp.frame_out = r.current_frame;
      end else begin
        found = 1'b0;
        for (w = 0; w < pfba_pkg::MAP_WORDS && !found; w++) begin
          if (used_words[w] != '1) begin
            for (b = 0; b < pfba_pkg::MAP_WORD_BITS && !found; b++) begin
              if (!used_words[w][b]) begin
                found              = 1'b1;
                used_words[w][b]   = 1'b1;
                rsp.status         = pfba_pkg::ST_ALLOCATED;
                rsp.frame_out      = pfba_pkg::frame_t'(w * pfba_pkg::MAP_WORD_BITS + b);
                rsp.present_bit    = 1'b1;
                rsp.rw_bit         = r.writable;
                rsp.user_bit       = ~r.kernel_page;
              end
            end
          end
        end
        if (!found) rsp.status = pfba_pkg::ST_NO_FRAME;
      end
    end else if (r.current_frame != '0) begin
      w = r.current_frame / pfba_pkg::MAP_WORD_BITS;
      b = r.current_frame % pfba_pkg::MAP_WORD_BITS;
      if (w < pfba_pkg::MAP_WORDS) used_words[w][b] = 1'b0;
      rsp.status = pfba_pkg::ST_FREED;
    end
    status_count[rsp.status]++;
    pending_results.push_back(rsp);
    return rsp;
  endfunction

  function void flag_field(string field, logic [11:0] want, logic [11:0] got);
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    mismatches++;
  endfunction

  // Compare one result with the oldest prediction.
  function void check_result(pfba_pkg::rsp_t got);
    pfba_pkg::rsp_t want;
    if (pending_results.size() == 0) begin
      $display("%0t ns: result %h with no item pending", $time, got);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status)
      flag_field("status", 12'(want.status), 12'(got.status));
    if (got.frame_out !== want.frame_out) flag_field("frame_out", want.frame_out, got.frame_out);
    if (got.present_bit !== want.present_bit)
      flag_field("present_bit", 12'(want.present_bit), 12'(got.present_bit));
    if (got.rw_bit !== want.rw_bit)
      flag_field("rw_bit", 12'(want.rw_bit), 12'(got.rw_bit));
    if (got.user_bit !== want.user_bit)
      flag_field("user_bit", 12'(want.user_bit), 12'(got.user_bit));
  endfunction
endclass

module testbench;
  import pfba_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned DRAIN_LIMIT  = 1000;
  localparam int unsigned SETTLE       = 8;    // margin for the last map access to finish

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t req_i  = '0;
  logic done_o;
  rsp_t rsp_o;

  frame_map_scoreboard frame_ledger = new();

  // Frames this side believes are mapped; frees of mapped entries draw on it.
  frame_t      mapped_frames [$];
  rsp_t        last_booked;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned waited;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  page_frame_bitmap_allocator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // Result side: the strobe lasts one cycle and cannot be held off, so check
  // every strobed result at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        frame_ledger.check_result(rsp_o);
      end else if (done_o !== 1'b0) begin
        $display("%0t ns: done_o unknown, expected 0 or 1, got %b", $time, done_o);
        frame_ledger.mismatches++;
      end
    end
  end

  function automatic req_t make_req(op_e op, frame_t cur, logic kern, logic wr);
    req_t r;
    r.opcode        = op;
    r.current_frame = cur;
    r.kernel_page   = kern;
    r.writable      = wr;
    return r;
  endfunction

  // Drop start and fill the request bus with junk while idle.
  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start = 1'b0;
      req_i = req_t'($urandom);
    end
  endtask

  // Bursts of random length, random gaps between them; now and then a long
  // burst so that back-to-back items hit every phase of the map access.
  task automatic pace();
    if (burst_left == 0) begin
      idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Present one item at the falling edge and hold it until the block takes it.
  task automatic send(req_t r);
    pace();
    @(negedge clk_i);
    start = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy !== 1'b0);
    last_booked = frame_ledger.book_request(r);
    if (last_booked.status == ST_ALLOCATED && last_booked.frame_out != '0)
      mapped_frames.push_back(last_booked.frame_out);
    items_sent++;
  endtask

  task automatic alloc_page(logic kern, logic wr);
    send(make_req(OP_ALLOC, '0, kern, wr));
  endtask

  task automatic release_frame(frame_t f);
    send(make_req(OP_FREE, f, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
  endtask

  // Mostly proper alloc/free traffic, with some mapped allocs and stray frees.
  task automatic random_item();
    int unsigned pick;
    int unsigned idx;
    frame_t      f;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      alloc_page(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if (pick < 75 && mapped_frames.size() != 0) begin
      idx = $urandom_range(0, mapped_frames.size() - 1);
      f   = mapped_frames[idx];
      mapped_frames.delete(idx);
      release_frame(f);
    end else if (pick < 85) begin
      send(make_req(OP_ALLOC, frame_t'($urandom_range(1, NUM_FRAMES - 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    end else if (pick < 93) begin
      release_frame(frame_t'($urandom));
    end else begin
      release_frame('0);
    end
  endtask

  initial begin
    // Hold reset, then release it at a falling edge.
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: frame zero goes out first and then reads as unmapped.
    alloc_page(1'b0, 1'b1);
    release_frame('0);
    alloc_page(1'b1, 1'b0);
    send(make_req(OP_ALLOC, frame_t'(NUM_FRAMES - 1), 1'b1, 1'b1));
    send(make_req(OP_ALLOC, frame_t'(1), 1'b0, 1'b0));
    release_frame(frame_t'(1));
    alloc_page(1'b1, 1'b1);
    release_frame(frame_t'(NUM_FRAMES - 1));
    release_frame(frame_t'(NUM_FRAMES / 2));
    alloc_page(1'b0, 1'b0);
    release_frame(frame_t'(2));
    release_frame(frame_t'(1));
    alloc_page(1'b1, 1'b0);
    alloc_page(1'b0, 1'b1);
    alloc_page(1'b1, 1'b1);

    // Random traffic on a mostly empty map.
    repeat (RANDOM_ITEMS / 2) random_item();

    // Open holes at the top frame and across a word boundary, then refill.
    release_frame(frame_t'(NUM_FRAMES - 1));
    alloc_page(1'b0, 1'b1);
    release_frame(frame_t'(MAP_WORD_BITS));
    release_frame(frame_t'(MAP_WORD_BITS - 1));
    alloc_page(1'b1, 1'b0);
    alloc_page(1'b0, 1'b0);
    alloc_page(1'b1, 1'b1);

    // More random traffic, where holes come and go.
    repeat (RANDOM_ITEMS - RANDOM_ITEMS / 2) random_item();

    idle_cycles(1);

    // Drain: wait for every predicted result, then let the block settle.
    waited = 0;
    while (frame_ledger.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE) @(posedge clk_i);
    if (frame_ledger.pending_results.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time,
               frame_ledger.pending_results.size());
      frame_ledger.mismatches += frame_ledger.pending_results.size();
    end

    $display("Sent %0d items: %0d allocated, %0d freed, %0d unchanged, %0d out of frames.",
             items_sent, frame_ledger.status_count[ST_ALLOCATED],
             frame_ledger.status_count[ST_FREED], frame_ledger.status_count[ST_UNCHANGED],
             frame_ledger.status_count[ST_NO_FRAME]);
    $display("Frame zero, word boundary and top frame cases ran; %0d mismatches seen.",
             frame_ledger.mismatches);
    if (frame_ledger.mismatches == 0) begin
      $display("PASS page_frame_bitmap_allocator");
    end else begin
      $display("FAIL page_frame_bitmap_allocator");
    end
    $finish;
  end

  // Bound the run with a timeout.
  initial begin
    #5_000_000;
    $display("Timeout: run did not complete");
    $display("FAIL page_frame_bitmap_allocator");
    $finish;
  end

endmodule
